// ----- rtl/mbd_pkg.sv -----
// shared types and constants for the multipart boundary deframer
package mbd_pkg;

  localparam int MAX_TOKEN  = 70;
  localparam int PREFIX_LEN = 4;
  localparam int WIN_DEPTH  = MAX_TOKEN + PREFIX_LEN;

  localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
  localparam int TCNT_W    = $clog2(MAX_TOKEN + 1);
  localparam int TOK_IDX_W = $clog2(MAX_TOKEN);

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] BND_PREFIX [PREFIX_LEN] = '{8'h0D, 8'h0A, 8'h2D, 8'h2D};

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_TOKEN = 2'd1,
    OP_BODY  = 2'd2,
    OP_END   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_NOBOUND  = 2'd2,
    KIND_TOOLONG  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

// ----- rtl/mbd_stream_if.sv -----
// stream interfaces for body items and result items
interface mbd_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface mbd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;

  modport source (output valid, output kind, output out_byte, input ready);
  modport sink   (input valid, input kind, input out_byte, output ready);
endinterface

// ----- rtl/multipart_boundary_deframer.sv -----
// top level: input register, deframer core and result queue
// a result passes the input register and then the result queue on its way out
// throughput: one input transaction per cycle while the result queue has room
// a stalled result port keeps intake going until the two-entry result queue and the input stage are full
// reset: synchronous active-high rst clears phase, counts, input stage and queue
// token store and window payload are not reset; only filled entries are compared
module multipart_boundary_deframer (
  input logic          clk,
  input logic          rst,
  mbd_item_if.sink     item,
  mbd_result_if.source result
);
  import mbd_pkg::*;

  // input register stage
  logic       stg_valid;
  op_t        stg_op;
  logic [7:0] stg_byte;

  // handshake between stage, core and queue
  logic       room;
  logic       fire;
  logic       accept;
  logic       pop;
  logic       head_valid;
  out_item_t  head_data;
  res_t       core_res;

  // the staged item moves through the core whenever the queue can take a result
  assign fire       = stg_valid && room;
  assign item.ready = !stg_valid || room;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (fire) begin
      stg_valid <= 1'b0;
    end
  end

  // payload of the stage, loaded on each accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      stg_op   <= op_t'(item.op);
      stg_byte <= item.data_byte;
    end
  end

  // core: header scan, token append, window shift and boundary compare
  mbd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .op        (stg_op),
    .data_byte (stg_byte),
    .res       (core_res)
  );

  // result queue acts as the result register plus skid entry
  assign pop = head_valid && result.ready;

  mbd_out_q u_out_q (
    .clk        (clk),
    .rst        (rst),
    .push       (core_res.valid),
    .push_data  (core_res.item),
    .pop        (pop),
    .room       (room),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign result.valid    = head_valid;
  assign result.kind     = head_data.kind;
  assign result.out_byte = head_data.out_byte;

endmodule

// ----- rtl/mbd_core.sv -----
// header scan, token store, boundary window and parallel compare
module mbd_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  mbd_pkg::op_t  op,
  input  logic [7:0]    data_byte,
  output mbd_pkg::res_t res
);
  import mbd_pkg::*;

  phase_t            phase;
  logic [1:0]        crlf_progress;
  logic [7:0]        token_store [MAX_TOKEN];
  logic [TCNT_W-1:0] token_count;
  logic [7:0]        window [WIN_DEPTH];
  logic [CNT_W-1:0]  window_fill;

  logic [7:0]        win_ins [WIN_DEPTH];
  logic [7:0]        win_shift [WIN_DEPTH];
  logic [7:0]        bnd [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] hit;
  logic [CNT_W-1:0]  blen;
  logic              full;
  logic              match;
  logic              tok_full;
  logic [7:0]        hdr_expect;

  assign blen       = CNT_W'(PREFIX_LEN) + CNT_W'(token_count);
  assign full       = (window_fill + CNT_W'(1)) >= blen;
  assign match      = &hit;
  assign tok_full   = token_count >= TCNT_W'(MAX_TOKEN);
  assign hdr_expect = crlf_progress[0] ? CHAR_LF : CHAR_CR;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_win
    if (i < PREFIX_LEN) begin : g_pre
      assign bnd[i] = BND_PREFIX[i];
    end else begin : g_tok
      assign bnd[i] = token_store[i-PREFIX_LEN];
    end
    if (i < WIN_DEPTH - 1) begin : g_sh
      assign win_shift[i] = win_ins[i+1];
    end else begin : g_last
      assign win_shift[i] = 8'd0;
    end
    // new byte lands at the fill position
    assign win_ins[i] = (window_fill == CNT_W'(i)) ? data_byte : window[i];
    // positions beyond the boundary length do not take part
    assign hit[i] = (win_ins[i] == bnd[i]) || (CNT_W'(i) >= blen);
  end

  always_comb begin
    res = '{valid: 1'b0, item: '{kind: KIND_DATA, out_byte: 8'd0}};
    if (fire) begin
      unique case (op)
        OP_CLEAR: ;
        OP_TOKEN: begin
          if (tok_full) begin
            res.valid     = 1'b1;
            res.item.kind = KIND_TOOLONG;
          end
        end
        OP_END: begin
          if (phase == PH_HEADER || phase == PH_DATA) begin
            res.valid     = 1'b1;
            res.item.kind = KIND_NOBOUND;
          end
        end
        OP_BODY: begin
          if (phase == PH_DATA && full) begin
            res.valid = 1'b1;
            if (match) begin
              res.item.kind = KIND_COMPLETE;
            end else begin
              res.item.kind     = KIND_DATA;
              res.item.out_byte = win_ins[0];
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      crlf_progress <= 2'd0;
      token_count   <= '0;
      window_fill   <= '0;
    end else if (fire) begin
      unique case (op)
        OP_CLEAR: begin
          phase         <= PH_HEADER;
          crlf_progress <= 2'd0;
          token_count   <= '0;
          window_fill   <= '0;
        end
        OP_TOKEN: begin
          if (!tok_full) begin
            token_count <= token_count + TCNT_W'(1);
          end
        end
        OP_END: ;
        OP_BODY: begin
          if (phase == PH_HEADER) begin
            if (data_byte == hdr_expect) begin
              if (crlf_progress == 2'd3) begin
                crlf_progress <= 2'd0;
                phase         <= PH_DATA;
              end else begin
                crlf_progress <= crlf_progress + 2'd1;
              end
            end else begin
              crlf_progress <= (data_byte == CHAR_CR) ? 2'd1 : 2'd0;
            end
          end else if (phase == PH_DATA) begin
            if (!full) begin
              window_fill <= window_fill + CNT_W'(1);
            end else if (match) begin
              phase <= PH_DONE;
            end
            // on release the fill count stays: one in, one out
          end
        end
      endcase
    end
  end

  // window contents above the fill count are never compared, so no clearing
  always_ff @(posedge clk) begin
    if (fire && op == OP_BODY && phase == PH_DATA) begin
      if (!full) begin
        window <= win_ins;
      end else if (!match) begin
        window <= win_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && op == OP_TOKEN && !tok_full) begin
      token_store[token_count[TOK_IDX_W-1:0]] <= data_byte;
    end
  end

endmodule

// ----- rtl/mbd_out_q.sv -----
// two-entry result queue that decouples the core from the result stall
module mbd_out_q (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mbd_pkg::out_item_t push_data,
  input  logic               pop,
  output logic               room,
  output logic               head_valid,
  output mbd_pkg::out_item_t head_data
);
  import mbd_pkg::*;

  out_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign room       = count != 2'd2;
  assign head_valid = count != 2'd0;
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// ----- rtl/mbd_checker.sv -----
// port-level checker for the multipart boundary deframer, with its bind
module mbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [1:0] result_kind,
  input logic [7:0] result_out_byte
);
  import mbd_pkg::*;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // intake only stalls when results are waiting
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid)
    else $error("intake stalled with no result pending");

  // only data results carry a byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind != KIND_DATA) |-> result_out_byte == 8'd0)
    else $error("non-data result with nonzero byte");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(result_kind) && $stable(result_out_byte)))
    else $error("stalled result changed");

endmodule

bind multipart_boundary_deframer mbd_checker u_mbd_checker (
  .clk             (clk),
  .rst             (rst),
  .item_ready      (item.ready),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .result_kind     (result.kind),
  .result_out_byte (result.out_byte)
);

// ----- test/tb.sv -----
// self-checking testbench for the multipart boundary deframer
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbd_pkg::*;

  localparam int          RANDOM_ITEMS = 1850;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          TAIL_CYCLES  = 8;
  localparam logic [7:0]  CHAR_DASH    = 8'h2D;

  logic clk;
  logic rst;

  mbd_item_if   item_bus ();
  mbd_result_if res_bus ();

  multipart_boundary_deframer i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (res_bus)
  );

  int unsigned err_cnt;
  int unsigned sent_cnt;
  int unsigned cycle_cnt;
  bit          steady;       // no idling on either side while set

  // mirror of the deframer state
  phase_t      mir_phase;
  logic [1:0]  mir_crlf;
  logic [7:0]  mir_token [MAX_TOKEN];
  int          mir_tok_cnt;
  logic [7:0]  mir_window [$];

  // results still owed by the block, oldest first
  out_item_t   out_items_due [$];

  // token of the request that the stimulus is building
  logic [7:0]  req_token [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- mirror

  function automatic void mirror_clear();
    mir_phase   = PH_HEADER;
    mir_crlf    = 2'd0;
    mir_tok_cnt = 0;
    mir_window.delete();
  endfunction

  function automatic void push_due(kind_t k, logic [7:0] v);
    out_items_due.push_back(out_item_t'{kind: k, out_byte: v});
  endfunction

  // advance the mirror by one accepted transaction
  function automatic void predict_deframe(op_t op, logic [7:0] b);
    logic [7:0] hdr_want;
    logic [7:0] bnd_byte;
    int         blen;
    int         i;
    bit         hit;
    case (op)
      OP_CLEAR: mirror_clear();
      OP_TOKEN: begin
        if (mir_tok_cnt >= MAX_TOKEN) begin
          push_due(KIND_TOOLONG, 8'h00);
        end else begin
          mir_token[mir_tok_cnt] = b;
          mir_tok_cnt++;
        end
      end
      OP_END: begin
        if (mir_phase == PH_HEADER || mir_phase == PH_DATA) push_due(KIND_NOBOUND, 8'h00);
      end
      OP_BODY: begin
        if (mir_phase == PH_HEADER) begin
          // CR LF CR LF: even positions want CR, odd ones LF
          hdr_want = mir_crlf[0] ? CHAR_LF : CHAR_CR;
          if (b == hdr_want) begin
            if (mir_crlf == 2'd3) begin
              mir_crlf  = 2'd0;
              mir_phase = PH_DATA;
            end else begin
              mir_crlf = mir_crlf + 2'd1;
            end
          end else begin
            mir_crlf = (b == CHAR_CR) ? 2'd1 : 2'd0;
          end
        end else if (mir_phase == PH_DATA) begin
          if (mir_window.size() >= WIN_DEPTH) void'(mir_window.pop_back());
          mir_window.push_back(b);
          blen = PREFIX_LEN + mir_tok_cnt;
          if (mir_window.size() >= blen) begin
            hit = 1'b1;
            for (i = 0; i < blen; i++) begin
              bnd_byte = (i < PREFIX_LEN) ? BND_PREFIX[i] : mir_token[i - PREFIX_LEN];
              if (mir_window[i] != bnd_byte) hit = 1'b0;
            end
            if (hit) begin
              mir_phase = PH_DONE;
              push_due(KIND_COMPLETE, 8'h00);
            end else begin
              push_due(KIND_DATA, mir_window.pop_front());
            end
          end
        end
      end
    endcase
  endfunction

  // ------------------------------------------------------ monitor and check

  // prediction and checking share one process, so no edge-ordering race
  always @(posedge clk) begin : bus_watch
    out_item_t want;
    if (!rst) begin
      if (item_bus.valid && item_bus.ready) predict_deframe(op_t'(item_bus.op), item_bus.data_byte);
      if (res_bus.valid && res_bus.ready) begin
        if (out_items_due.size() == 0) begin
          $error("unexpected result: kind %0d, out_byte %02h", res_bus.kind, res_bus.out_byte);
          err_cnt++;
        end else begin
          want = out_items_due.pop_front();
          if (res_bus.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, res_bus.kind);
            err_cnt++;
          end
          if (res_bus.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, res_bus.out_byte);
            err_cnt++;
          end
        end
      end
    end
  end

  // -------------------------------------------------------- idling helpers

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // result side: runs of ready broken by random stalls
  initial begin : result_stalls
    int unsigned run_len;
    int unsigned stall_len;
    res_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      run_len = $urandom_range(1, 30);
      res_bus.ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len != 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // ------------------------------------------------------- stimulus helpers

  // one transaction; returns at the edge where it was accepted, valid left high
  task automatic send_item(op_t op, logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid     <= 1'b1;
    item_bus.op        <= op;
    item_bus.data_byte <= b;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    sent_cnt++;
  endtask

  // stop sending until every owed result has come back
  task automatic hold_until_drained();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (out_items_due.size() != 0) @(posedge clk);
  endtask

  // first upto bytes of CR LF '-' '-' token
  task automatic send_boundary(int unsigned upto);
    int unsigned i;
    for (i = 0; i < upto; i++) begin
      if (i < PREFIX_LEN) send_item(OP_BODY, BND_PREFIX[i]);
      else send_item(OP_BODY, req_token[i - PREFIX_LEN]);
    end
  endtask

  task automatic send_header_end();
    send_item(OP_BODY, CHAR_CR);
    send_item(OP_BODY, CHAR_LF);
    send_item(OP_BODY, CHAR_CR);
    send_item(OP_BODY, CHAR_LF);
  endtask

  function automatic logic [7:0] pick_token_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return CHAR_DASH;
    if (r < 22) return CHAR_CR;
    if (r < 28) return CHAR_LF;
    return 8'($urandom);
  endfunction

  // biased toward boundary characters so near misses are common
  function automatic logic [7:0] pick_body_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60 || req_token.size() == 0 && r >= 88) return 8'($urandom);
    if (r < 70) return CHAR_CR;
    if (r < 78) return CHAR_LF;
    if (r < 88) return CHAR_DASH;
    return req_token[$urandom_range(0, req_token.size() - 1)];
  endfunction

  // ------------------------------------------------------------------ tests

  // extremes, every op, header restart, repeated body end, ignored tail
  task automatic test_directed();
    send_item(OP_CLEAR, 8'hFF);
    req_token.delete();
    req_token.push_back(8'h00);
    req_token.push_back(8'hFF);
    send_item(OP_TOKEN, 8'h00);
    send_item(OP_TOKEN, 8'hFF);
    send_item(OP_END, 8'h00);          // body end during the header
    send_item(OP_BODY, CHAR_CR);
    send_item(OP_BODY, CHAR_LF);
    send_item(OP_BODY, CHAR_CR);
    send_item(OP_BODY, CHAR_CR);       // breaks the match but restarts it at one
    send_item(OP_BODY, CHAR_LF);
    send_item(OP_BODY, CHAR_CR);
    send_item(OP_BODY, CHAR_LF);       // now in the data phase
    send_item(OP_BODY, 8'h00);
    send_item(OP_BODY, 8'hFF);
    send_item(OP_BODY, CHAR_CR);
    send_item(OP_END, 8'hFF);          // body end in data, state kept
    send_item(OP_END, 8'h55);          // and once more
    send_boundary(PREFIX_LEN + 2);
    send_item(OP_BODY, 8'h41);         // ignored after completion
    send_item(OP_END, 8'hAA);          // no result after completion
    hold_until_drained();
  endtask

  // full-length token, dropped extras, then the longest boundary
  task automatic test_token_overflow();
    logic [7:0] b;
    send_item(OP_CLEAR, 8'h00);
    req_token.delete();
    repeat (MAX_TOKEN) begin
      b = pick_token_byte();
      req_token.push_back(b);
      send_item(OP_TOKEN, b);
    end
    repeat (3) send_item(OP_TOKEN, 8'($urandom));
    send_header_end();
    repeat (80) send_item(OP_BODY, pick_body_byte());
    send_boundary(PREFIX_LEN + MAX_TOKEN);
    send_item(OP_BODY, 8'($urandom));
    send_item(OP_END, 8'($urandom));
    hold_until_drained();
  endtask

  // one upload: token, header, data with near misses, ending or not
  task automatic run_request();
    int unsigned r;
    int unsigned tlen;
    int unsigned n;
    logic [7:0]  b;
    // now and then some junk ahead of the clear
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, 5);
      repeat (n) send_item(op_t'($urandom_range(0, 3)), 8'($urandom));
    end
    send_item(OP_CLEAR, 8'($urandom));
    req_token.delete();
    r = $urandom_range(0, 99);
    if (r < 3) tlen = 0;
    else if (r < 75) tlen = $urandom_range(1, 8);
    else if (r < 95) tlen = $urandom_range(9, 40);
    else tlen = $urandom_range(60, MAX_TOKEN);
    repeat (tlen) begin
      b = pick_token_byte();
      req_token.push_back(b);
      send_item(OP_TOKEN, b);
    end
    if (tlen == MAX_TOKEN) begin
      n = $urandom_range(1, 3);
      repeat (n) send_item(OP_TOKEN, 8'($urandom));
    end
    if ($urandom_range(0, 9) == 0) send_item(OP_END, 8'($urandom));
    n = $urandom_range(0, 12);
    repeat (n) send_item(OP_BODY, pick_body_byte());
    send_header_end();
    n = $urandom_range(0, 30);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_boundary($urandom_range(1, PREFIX_LEN + req_token.size() - 1));
      end else if (r < 14) begin
        // token grows after the header
        b = pick_token_byte();
        if (req_token.size() < MAX_TOKEN) req_token.push_back(b);
        send_item(OP_TOKEN, b);
      end else if (r < 16) begin
        send_item(OP_END, 8'($urandom));
      end else begin
        send_item(OP_BODY, pick_body_byte());
      end
    end
    if ($urandom_range(0, 99) < 75) begin
      send_boundary(PREFIX_LEN + req_token.size());
      n = $urandom_range(0, 3);
      repeat (n) send_item(OP_BODY, 8'($urandom));
    end
    send_item(OP_END, 8'($urandom));
  endtask

  task automatic test_random_requests(int unsigned target);
    bit first;
    first = 1'b1;
    while (sent_cnt < target) begin
      steady = ($urandom_range(0, 5) == 0);
      if (first || $urandom_range(0, 7) == 0) hold_until_drained();
      first = 1'b0;
      run_request();
    end
    steady = 1'b0;
  endtask

  // ------------------------------------------------------------------- main

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main_seq
    int unsigned target;
    err_cnt  = 0;
    sent_cnt = 0;
    steady   = 1'b0;
    mirror_clear();
    rst                <= 1'b1;
    item_bus.valid     <= 1'b0;
    item_bus.op        <= OP_CLEAR;
    item_bus.data_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_token_overflow();
    // random requests fill up the run to the overall item count
    target = RANDOM_ITEMS;
    test_random_requests(target);

    // let the last results drain, then a short tail for silent items
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mbd_pkg.sv
rtl/mbd_stream_if.sv
rtl/mbd_core.sv
rtl/mbd_out_q.sv
rtl/multipart_boundary_deframer.sv
rtl/mbd_checker.sv
test/tb.sv
